@@ src/msws_pkg.sv @@
// Shared types, constants and the sine lookup table for the multi-shape waveform sequencer.
package msws_pkg;

  localparam int TableSizeDef = 256;
  localparam int HalfPeriod   = 127;
  localparam int StepUnit     = 3000;
  localparam int StepHold     = 50;
  localparam int StepLevels   = 20;
  localparam int BudgetW      = 19;

  // Reciprocal of 10000 scaled by 2**45; exact for every 32-bit dividend.
  localparam logic [31:0] RecipMagic = 32'hD1B71759;
  localparam int          RecipShift = 45;

  typedef enum logic [2:0] {
    WaveNone   = 3'd0,
    WaveSine   = 3'd1,
    WaveSquare = 3'd2,
    WaveTri    = 3'd3,
    WaveRect   = 3'd4,
    WaveStep   = 3'd5,
    WaveSaw    = 3'd6
  } wave_e;

  typedef struct packed {
    logic               vld;
    logic               tick;
    logic               known;
    wave_e              mode;
    logic [BudgetW-1:0] budget;
  } msws_item_t;

  localparam logic [15:0] SineRom [256] = '{
    16'h8000, 16'h8324, 16'h8647, 16'h896a, 16'h8c8b, 16'h8fab, 16'h92c7, 16'h95e1,
    16'h98f8, 16'h9c0b, 16'h9f19, 16'ha223, 16'ha527, 16'ha826, 16'hab1f, 16'hae10,
    16'hb0fb, 16'hb3de, 16'hb6b9, 16'hb98c, 16'hbc56, 16'hbf17, 16'hc1cd, 16'hc47a,
    16'hc71c, 16'hc9b3, 16'hcc3f, 16'hcebf, 16'hd133, 16'hd39a, 16'hd5f5, 16'hd842,
    16'hda82, 16'hdcb3, 16'hded7, 16'he0eb, 16'he2f1, 16'he4e8, 16'he6cf, 16'he8a6,
    16'hea6d, 16'hec23, 16'hedc9, 16'hef5e, 16'hf0e2, 16'hf254, 16'hf3b5, 16'hf504,
    16'hf641, 16'hf76b, 16'hf884, 16'hf989, 16'hfa7c, 16'hfb5c, 16'hfc29, 16'hfce3,
    16'hfd89, 16'hfe1d, 16'hfe9c, 16'hff09, 16'hff61, 16'hffa6, 16'hffd8, 16'hfff5,
    16'hffff, 16'hfff5, 16'hffd8, 16'hffa6, 16'hff61, 16'hff09, 16'hfe9c, 16'hfe1d,
    16'hfd89, 16'hfce3, 16'hfc29, 16'hfb5c, 16'hfa7c, 16'hf989, 16'hf884, 16'hf76b,
    16'hf641, 16'hf504, 16'hf3b5, 16'hf254, 16'hf0e2, 16'hef5e, 16'hedc9, 16'hec23,
    16'hea6d, 16'he8a6, 16'he6cf, 16'he4e8, 16'he2f1, 16'he0eb, 16'hded7, 16'hdcb3,
    16'hda82, 16'hd842, 16'hd5f5, 16'hd39a, 16'hd133, 16'hcebf, 16'hcc3f, 16'hc9b3,
    16'hc71c, 16'hc47a, 16'hc1cd, 16'hbf17, 16'hbc56, 16'hb98c, 16'hb6b9, 16'hb3de,
    16'hb0fb, 16'hae10, 16'hab1f, 16'ha826, 16'ha527, 16'ha223, 16'h9f19, 16'h9c0b,
    16'h98f8, 16'h95e1, 16'h92c7, 16'h8fab, 16'h8c8b, 16'h896a, 16'h8647, 16'h8324,
    16'h8000, 16'h7cdb, 16'h79b8, 16'h7695, 16'h7374, 16'h7054, 16'h6d38, 16'h6a1e,
    16'h6707, 16'h63f4, 16'h60e6, 16'h5ddc, 16'h5ad8, 16'h57d9, 16'h54e0, 16'h51ef,
    16'h4f04, 16'h4c21, 16'h4946, 16'h4673, 16'h43a9, 16'h40e8, 16'h3e32, 16'h3b85,
    16'h38e3, 16'h364c, 16'h33c0, 16'h3140, 16'h2ecc, 16'h2c65, 16'h2a0a, 16'h27bd,
    16'h257d, 16'h234c, 16'h2128, 16'h1f14, 16'h1d0e, 16'h1b17, 16'h1930, 16'h1759,
    16'h1592, 16'h13dc, 16'h1236, 16'h10a1, 16'h0f1d, 16'h0dab, 16'h0c4a, 16'h0afb,
    16'h09be, 16'h0894, 16'h077b, 16'h0676, 16'h0583, 16'h04a3, 16'h03d6, 16'h031c,
    16'h0276, 16'h01e2, 16'h0163, 16'h00f6, 16'h009e, 16'h0059, 16'h0027, 16'h000a,
    16'h0000, 16'h000a, 16'h0027, 16'h0059, 16'h009e, 16'h00f6, 16'h0163, 16'h01e2,
    16'h0276, 16'h031c, 16'h03d6, 16'h04a3, 16'h0583, 16'h0676, 16'h077b, 16'h0894,
    16'h09be, 16'h0afb, 16'h0c4a, 16'h0dab, 16'h0f1d, 16'h10a1, 16'h1236, 16'h13dc,
    16'h1592, 16'h1759, 16'h1930, 16'h1b17, 16'h1d0e, 16'h1f14, 16'h2128, 16'h234c,
    16'h257d, 16'h27bd, 16'h2a0a, 16'h2c65, 16'h2ecc, 16'h3140, 16'h33c0, 16'h364c,
    16'h38e3, 16'h3b85, 16'h3e32, 16'h40e8, 16'h43a9, 16'h4673, 16'h4946, 16'h4c21,
    16'h4f04, 16'h51ef, 16'h54e0, 16'h57d9, 16'h5ad8, 16'h5ddc, 16'h60e6, 16'h63f4,
    16'h6707, 16'h6a1e, 16'h6d38, 16'h7054, 16'h7374, 16'h7695, 16'h79b8, 16'h7cdb
  };

  // Staircase level: rises 0..30000 over the first eleven indexes, then falls back.
  function automatic logic [15:0] step_level(input logic [4:0] li);
    logic [4:0]  lvl;
    logic [20:0] prod;
    begin
      lvl  = (li < 5'(StepLevels / 2)) ? li : 5'(5'(StepLevels) - li);
      prod = 21'(lvl) * 21'(StepUnit);
      return prod[15:0];
    end
  endfunction

endpackage

@@ src/msws_budget.sv @@
// Input register and multiply pipeline that turns a command into its sample budget.
module msws_budget
  import msws_pkg::*;
#(
  parameter int TABLE_SIZE = TableSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        in_vld_i,
  input  logic        func_i,
  input  logic [15:0] wave_type_i,
  input  logic [15:0] duration_i,
  input  logic [15:0] frequency_i,
  output msws_item_t  item_o
);

  localparam logic [10:0] MultSine = 11'(TABLE_SIZE);

  logic        vld0_q, vld1_q, vld2_q, vld3_q;
  logic        tick0_q, tick1_q, tick2_q, tick3_q;
  logic [15:0] type0_q, dur0_q, freq0_q;
  logic        known1_q, known2_q, known3_q;
  wave_e       mode1_q, mode2_q, mode3_q;
  logic [31:0] prod1_q, prod2_q;
  logic [BudgetW-1:0] quo3_q;

  logic        known0;
  wave_e       mode0;
  logic [31:0] prod1_d, prod2_d;
  logic [42:0] prod_sine;
  logic [63:0] prod_recip;

  assign known0 = (type0_q >= 16'd1) && (type0_q <= 16'd6);
  assign mode0  = known0 ? wave_e'(type0_q[2:0]) : WaveNone;
  assign prod1_d = 32'(dur0_q) * 32'(freq0_q);

  assign prod_sine = 43'(prod1_q) * 43'(MultSine);
  assign prod2_d   = ((mode1_q == WaveSine) || (mode1_q == WaveRect)) ?
                     prod_sine[31:0] : {prod1_q[23:0], 8'h00};

  assign prod_recip = 64'(prod2_q) * 64'(RecipMagic);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (adv_i) begin
      vld0_q <= in_vld_i;
      vld1_q <= vld0_q;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tick0_q  <= func_i;
      type0_q  <= wave_type_i;
      dur0_q   <= duration_i;
      freq0_q  <= frequency_i;
      tick1_q  <= tick0_q;
      known1_q <= known0;
      mode1_q  <= mode0;
      prod1_q  <= prod1_d;
      tick2_q  <= tick1_q;
      known2_q <= known1_q;
      mode2_q  <= mode1_q;
      prod2_q  <= prod2_d;
      tick3_q  <= tick2_q;
      known3_q <= known2_q;
      mode3_q  <= mode2_q;
      quo3_q   <= prod_recip[RecipShift +: BudgetW];
    end
  end

  assign item_o = '{vld: vld3_q, tick: tick3_q, known: known3_q, mode: mode3_q,
                    budget: quo3_q};

endmodule

@@ src/msws_core.sv @@
// Run state, waveform sample generation and the output word register.
module msws_core
  import msws_pkg::*;
#(
  parameter int TABLE_SIZE = TableSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  msws_item_t  item_i,
  output logic        out_vld_o,
  output logic        is_sample_o,
  output logic [15:0] sample_o,
  output logic        done_res_o,
  output logic        status_o
);

  localparam int TsW     = $clog2(TABLE_SIZE);
  localparam int PW      = (TsW > 8) ? TsW : 8;
  localparam int FW      = TsW + 1;
  localparam int IdxStep = 256 / TABLE_SIZE;
  localparam int IdxFrac = 256 % TABLE_SIZE;

  logic               busy_q, busy_d;
  wave_e              mode_q, mode_d;
  logic [BudgetW-1:0] remaining_q, remaining_d;
  logic [PW-1:0]      phase_q, phase_d;
  logic [7:0]         idx_q, idx_d;
  logic [TsW-1:0]     frac_q, frac_d;
  logic [5:0]         hold_q, hold_d;
  logic [4:0]         lvl_q, lvl_d;

  logic        out_vld_q, is_sample_q, done_q, status_q;
  logic [15:0] sample_q;
  logic        res_vld, res_is, res_done, res_st;
  logic [15:0] res_smp;

  logic [15:0]        smp;
  logic [PW-1:0]      phase_nx;
  logic [7:0]         idx_nx;
  logic [TsW-1:0]     frac_nx;
  logic [5:0]         hold_nx;
  logic [4:0]         lvl_nx;
  logic [FW-1:0]      frac_sum;
  logic [7:0]         tri_val;
  logic [15:0]        rom_val;
  logic [BudgetW-1:0] count;

  assign frac_sum = FW'(frac_q) + FW'(IdxFrac);
  assign tri_val  = (phase_q < PW'(HalfPeriod)) ? phase_q[7:0] :
                    8'(PW'(2 * HalfPeriod) - phase_q);
  assign rom_val  = (mode_q == WaveRect) ? SineRom[{1'b0, idx_q[6:0]}] : SineRom[idx_q];

  always_comb begin
    smp      = '0;
    phase_nx = phase_q;
    idx_nx   = idx_q;
    frac_nx  = frac_q;
    hold_nx  = hold_q;
    lvl_nx   = lvl_q;
    case (mode_q)
      WaveSine, WaveRect: begin
        smp = {1'b0, rom_val[15:1]};
        if (phase_q == PW'(TABLE_SIZE - 1)) begin
          phase_nx = '0;
          idx_nx   = '0;
          frac_nx  = '0;
        end else begin
          phase_nx = phase_q + PW'(1);
          if (frac_sum >= FW'(TABLE_SIZE)) begin
            frac_nx = TsW'(frac_sum - FW'(TABLE_SIZE));
            idx_nx  = idx_q + 8'(IdxStep) + 8'd1;
          end else begin
            frac_nx = TsW'(frac_sum);
            idx_nx  = idx_q + 8'(IdxStep);
          end
        end
      end
      WaveSquare, WaveTri: begin
        if (mode_q == WaveSquare) begin
          smp = (phase_q < PW'(HalfPeriod)) ? 16'hFFFF : 16'h0000;
        end else begin
          smp = {tri_val, 8'h00};
        end
        phase_nx = (phase_q == PW'(2 * HalfPeriod - 1)) ? '0 : phase_q + PW'(1);
      end
      WaveSaw: begin
        smp      = {phase_q[7:0], 8'h00};
        phase_nx = (phase_q == PW'(HalfPeriod - 1)) ? '0 : phase_q + PW'(1);
      end
      default: begin
        // Staircase; a run never carries the idle code, so only the step shape lands here.
        smp = step_level(lvl_q);
        if (hold_q == 6'(StepHold - 1)) begin
          hold_nx = '0;
          lvl_nx  = lvl_q + 5'd1;
        end else begin
          hold_nx = hold_q + 6'd1;
        end
      end
    endcase
  end

  always_comb begin
    case (item_i.mode)
      WaveStep:         count = BudgetW'(StepLevels * StepHold);
      WaveTri, WaveSaw: count = (item_i.budget == '0) ? '0 : item_i.budget - BudgetW'(1);
      default:          count = item_i.budget;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    mode_d      = mode_q;
    remaining_d = remaining_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    frac_d      = frac_q;
    hold_d      = hold_q;
    lvl_d       = lvl_q;
    res_vld     = 1'b0;
    res_is      = 1'b0;
    res_smp     = '0;
    res_done    = 1'b0;
    res_st      = 1'b0;
    if (item_i.vld) begin
      if (!item_i.tick) begin
        if (!busy_q) begin
          if (!item_i.known) begin
            res_vld  = 1'b1;
            res_done = 1'b1;
            res_st   = 1'b1;
          end else if (count == '0) begin
            res_vld  = 1'b1;
            res_done = 1'b1;
          end else begin
            busy_d      = 1'b1;
            mode_d      = item_i.mode;
            remaining_d = count;
            phase_d     = '0;
            idx_d       = '0;
            frac_d      = '0;
            hold_d      = '0;
            lvl_d       = '0;
          end
        end
      end else if (busy_q) begin
        res_vld     = 1'b1;
        res_is      = 1'b1;
        res_smp     = smp;
        remaining_d = remaining_q - BudgetW'(1);
        phase_d     = phase_nx;
        idx_d       = idx_nx;
        frac_d      = frac_nx;
        hold_d      = hold_nx;
        lvl_d       = lvl_nx;
        if (remaining_q == BudgetW'(1)) begin
          busy_d   = 1'b0;
          res_done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      mode_q      <= WaveNone;
      remaining_q <= '0;
      phase_q     <= '0;
      idx_q       <= '0;
      frac_q      <= '0;
      hold_q      <= '0;
      lvl_q       <= '0;
      out_vld_q   <= 1'b0;
    end else if (adv_i) begin
      busy_q      <= busy_d;
      mode_q      <= mode_d;
      remaining_q <= remaining_d;
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      frac_q      <= frac_d;
      hold_q      <= hold_d;
      lvl_q       <= lvl_d;
      out_vld_q   <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      is_sample_q <= res_is;
      sample_q    <= res_smp;
      done_q      <= res_done;
      status_q    <= res_st;
    end
  end

  assign out_vld_o   = out_vld_q;
  assign is_sample_o = is_sample_q;
  assign sample_o    = sample_q;
  assign done_res_o  = done_q;
  assign status_o    = status_q;

  // A completion word without a sample always closes its command.
  a_completion_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !is_sample_q) |-> done_q)
    else $error("completion word without done flag");

  // The unknown-type status never rides on a sample word.
  a_status_no_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && status_q) |-> !is_sample_q)
    else $error("error status on a sample word");

  // A run in progress always has samples left.
  a_busy_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (remaining_q != '0))
    else $error("busy with no samples left");

  // The end of a run is marked by its final sample word.
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> (out_vld_q && is_sample_q && done_q))
    else $error("run ended without a final sample word");

endmodule

@@ src/multi_shape_waveform_sequencer_top.sv @@
// Top level of the multi-shape waveform sequencer: handshake control and submodules.
//
//   Channel  Direction  Handshake                  Word fields
//   in       input      in_valid_i / in_stall_o    func_i, wave_type_i, duration_i, frequency_i
//   out      output     out_valid_o / out_stall_i  is_sample_o, sample_o, done_res_o, status_o
//
// One input word is accepted every cycle while the output is not stalled.
// Each accepted word passes the input register, then the three multiply stages of the
// budget, then the output register.
// Reset clears the run state and the pipeline valid flags; no clearing pass is needed.
// A stalled output word freezes the whole pipeline, and in_stall_o follows it.
module multi_shape_waveform_sequencer_top
  import msws_pkg::*;
#(
  parameter int TABLE_SIZE = TableSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [15:0] wave_type_i,
  input  logic [15:0] duration_i,
  input  logic [15:0] frequency_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_sample_o,
  output logic [15:0] sample_o,
  output logic        done_res_o,
  output logic        status_o
);

  logic       adv;
  msws_item_t item;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  msws_budget #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_budget (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_vld_i   (in_valid_i),
    .func_i     (func_i),
    .wave_type_i(wave_type_i),
    .duration_i (duration_i),
    .frequency_i(frequency_i),
    .item_o     (item)
  );

  msws_core #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .item_i     (item),
    .out_vld_o  (out_valid_o),
    .is_sample_o(is_sample_o),
    .sample_o   (sample_o),
    .done_res_o (done_res_o),
    .status_o   (status_o)
  );

endmodule

@@ tb/sv/tb_multi_shape_waveform_sequencer_top.sv @@
// Self-checking testbench for the multi-shape waveform sequencer top level.
`timescale 1ns / 100ps

module tb_multi_shape_waveform_sequencer_top
  import msws_pkg::*;
();

  localparam int Divisor     = 10000;
  localparam int IdlePct     = 6;
  localparam int LongHold    = 400;
  localparam int CycleLimit  = 400000;
  localparam int RandomItems = 60;

  localparam logic FuncStart = 1'b0;
  localparam logic FuncTick  = 1'b1;

  typedef struct packed {
    logic        is_sample;
    logic [15:0] sample;
    logic        done;
    logic        status;
  } dac_word_t;

  typedef struct {
    logic        func;
    logic [15:0] wave_type;
    logic [15:0] duration;
    logic [15:0] frequency;
    bit          drain;
  } cmd_word_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        func_i      = FuncTick;
  logic [15:0] wave_type_i = '0;
  logic [15:0] duration_i  = '0;
  logic [15:0] frequency_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        is_sample_o;
  logic [15:0] sample_o;
  logic        done_res_o;
  logic        status_o;

  multi_shape_waveform_sequencer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .wave_type_i (wave_type_i),
    .duration_i  (duration_i),
    .frequency_i (frequency_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_sample_o (is_sample_o),
    .sample_o    (sample_o),
    .done_res_o  (done_res_o),
    .status_o    (status_o)
  );

  cmd_word_t pending_words[$];
  dac_word_t dac_words_q[$];
  dac_word_t out_word;
  dac_word_t want_word;
  dac_word_t new_word;
  logic      has_word;
  cmd_word_t next_word;

  logic        in_taken   = 1'b0;
  int          in_count   = 0;
  int          seen_cnt   = 0;
  int          mismatches = 0;
  int          cycle_cnt  = 0;
  int          hold_left  = 0;
  int          holds_done = 0;
  int          queued     = 0;
  logic        calm;

  // Predicted sequencer state.
  logic        run_busy  = 1'b0;
  wave_e       run_mode  = WaveNone;
  logic [18:0] run_left  = '0;
  logic [7:0]  run_phase = '0;
  logic [5:0]  run_hold  = '0;
  logic [4:0]  run_level = '0;

  assign out_word = {is_sample_o, sample_o, done_res_o, status_o};
  assign calm     = (in_count >= 400) && (in_count < 900);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic known_wave(input logic [15:0] t);
    return (t >= 16'(WaveSine)) && (t <= 16'(WaveSaw));
  endfunction

  function automatic logic [18:0] run_length(input logic [15:0] t, input logic [15:0] d,
                                             input logic [15:0] f);
    logic [47:0] prod;
    logic [31:0] budget;
    begin
      prod   = 48'(TableSizeDef) * 48'(d) * 48'(f);
      budget = prod[31:0] / 32'(Divisor);
      if (t == 16'(WaveStep)) begin
        return 19'(StepLevels * StepHold);
      end else if (t == 16'(WaveTri) || t == 16'(WaveSaw)) begin
        return (budget > 0) ? 19'(budget - 1) : 19'd0;
      end
      return 19'(budget);
    end
  endfunction

  task automatic advance_sequencer(input logic fn, input logic [15:0] t, input logic [15:0] d,
                                   input logic [15:0] f, output logic got,
                                   output dac_word_t w);
    logic [18:0] cnt;
    logic [15:0] v;
    int          lvl;
    begin
      got = 1'b0;
      w   = '0;
      v   = '0;
      if (fn == FuncStart) begin
        if (run_busy) return;
        if (!known_wave(t)) begin
          got = 1'b1;
          w   = '{is_sample: 1'b0, sample: 16'h0, done: 1'b1, status: 1'b1};
          return;
        end
        cnt = run_length(t, d, f);
        if (cnt == 0) begin
          got = 1'b1;
          w   = '{is_sample: 1'b0, sample: 16'h0, done: 1'b1, status: 1'b0};
          return;
        end
        run_busy  = 1'b1;
        run_mode  = wave_e'(t[2:0]);
        run_left  = cnt;
        run_phase = '0;
        run_hold  = '0;
        run_level = '0;
      end else if (run_busy) begin
        case (run_mode)
          WaveSine: begin
            v = SineRom[8'((int'(run_phase) * 256) / TableSizeDef)] >> 1;
            run_phase = 8'((int'(run_phase) + 1) % TableSizeDef);
          end
          WaveRect: begin
            v = SineRom[8'((int'(run_phase) * 256) / TableSizeDef) & 8'd127] >> 1;
            run_phase = 8'((int'(run_phase) + 1) % TableSizeDef);
          end
          WaveSquare: begin
            v = (run_phase < HalfPeriod) ? 16'hFFFF : 16'h0000;
            run_phase = 8'((int'(run_phase) + 1) % (2 * HalfPeriod));
          end
          WaveTri: begin
            v = (run_phase < HalfPeriod) ? 16'(int'(run_phase) * 256)
                                         : 16'((2 * HalfPeriod - int'(run_phase)) * 256);
            run_phase = 8'((int'(run_phase) + 1) % (2 * HalfPeriod));
          end
          WaveSaw: begin
            v = 16'(int'(run_phase) * 256);
            run_phase = 8'((int'(run_phase) + 1) % HalfPeriod);
          end
          default: begin
            lvl = (run_level < StepLevels / 2) ? int'(run_level)
                                               : StepLevels - int'(run_level);
            v = 16'(lvl * StepUnit);
            run_hold = run_hold + 6'd1;
            if (run_hold >= StepHold) begin
              run_hold  = '0;
              run_level = run_level + 5'd1;
            end
          end
        endcase
        run_left = run_left - 19'd1;
        got = 1'b1;
        w   = '{is_sample: 1'b1, sample: v, done: (run_left == 0), status: 1'b0};
        if (run_left == 0) run_busy = 1'b0;
      end
    end
  endtask

  task automatic add_start(input logic [15:0] t, input logic [15:0] d, input logic [15:0] f,
                           input bit drain);
    pending_words.push_back('{FuncStart, t, d, f, drain});
    queued++;
  endtask

  task automatic add_ticks(input int n, input int noise_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        add_start(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
      end
      pending_words.push_back('{FuncTick, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0});
      queued++;
    end
  endtask

  task automatic add_random_run(input bit drain);
    logic [15:0] t;
    logic [15:0] d;
    logic [15:0] f;
    int          r;
    int          k;
    int          cnt;
    logic [2:0]  plain[5];
    begin
      plain = '{WaveSine, WaveSquare, WaveTri, WaveRect, WaveSaw};
      r     = $urandom_range(99);
      t     = 16'(plain[$urandom_range(4)]);
      d     = 16'($urandom_range(1, 40));
      f     = 16'($urandom_range(1, 40));
      if (r < 15) begin
        t = 16'($urandom);
        if (known_wave(t)) t = t | 16'h0008;
        d = 16'($urandom);
        f = 16'($urandom);
      end else if (r < 30) begin
        k = $urandom_range(3);
        if (k == 0) begin
          d = 16'h0;
          f = 16'($urandom);
        end else if (k == 1) begin
          d = 16'($urandom);
          f = 16'h0;
        end else if (k == 2) begin
          t = $urandom_range(1) ? 16'(WaveTri) : 16'(WaveSaw);
          d = 16'd1;
          f = 16'($urandom_range(40, 78));
        end else begin
          k = $urandom_range(9, 15);
          d = 16'(1 << k);
          f = 16'(1 << (24 - k));
        end
      end
      add_start(t, d, f, drain);
      cnt = known_wave(t) ? int'(run_length(t, d, f)) : 0;
      if (cnt > 0) add_ticks(cnt, 4);
      if ($urandom_range(99) < 10) add_ticks($urandom_range(1, 3), 0);
    end
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (pending_words.size() != 0 && !(pending_words[0].drain && dac_words_q.size() != 0)
          && (calm || $urandom_range(99) >= IdlePct)) begin
        next_word = pending_words.pop_front();
        func_i      <= next_word.func;
        wave_type_i <= next_word.wave_type;
        duration_i  <= next_word.duration;
        frequency_i <= next_word.frequency;
        in_valid_i  <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (holds_done < 2 && seen_cnt >= ((holds_done == 0) ? 150 : 1800)) begin
      hold_left   <= LongHold;
      holds_done  <= holds_done + 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_cnt <= seen_cnt + 1;
      if (dac_words_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: is_sample=%0b sample=%h done=%0b status=%0b",
                   out_word.is_sample, out_word.sample, out_word.done, out_word.status);
        end
      end else begin
        want_word = dac_words_q.pop_front();
        if (out_word !== want_word) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("word mismatch: expected is_sample=%0b sample=%h done=%0b status=%0b",
                     want_word.is_sample, want_word.sample, want_word.done, want_word.status);
            $display("                 actual is_sample=%0b sample=%h done=%0b status=%0b",
                     out_word.is_sample, out_word.sample, out_word.done, out_word.status);
          end
        end
      end
    end
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      in_count <= in_count + 1;
      advance_sequencer(func_i, wave_type_i, duration_i, frequency_i, has_word, new_word);
      if (has_word) dac_words_q.push_back(new_word);
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("multi_shape_waveform_sequencer_top regression: fail");
    $finish;
  end

  initial begin
    add_ticks(1, 0);
    add_start(16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
    add_start(16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    add_start(16'h0007, 16'h0001, 16'h0001, 1'b0);
    add_start(16'h8001, 16'h0064, 16'h0066, 1'b0);
    add_start(16'(WaveSine), 16'h0000, 16'hFFFF, 1'b0);
    add_start(16'(WaveSquare), 16'hFFFF, 16'h0000, 1'b0);
    add_start(16'(WaveSine), 16'd4096, 16'd4096, 1'b0);
    add_start(16'(WaveTri), 16'd40, 16'd1, 1'b0);
    add_start(16'(WaveSaw), 16'd40, 16'd1, 1'b0);
    add_start(16'(WaveSine), 16'd1, 16'd40, 1'b0);
    add_ticks(1, 0);
    add_start(16'(WaveSine), 16'd257, 16'd65321, 1'b0);
    add_ticks(10, 0);
    add_start(16'(WaveSquare), 16'd5, 16'd5, 1'b0);
    add_ticks(253, 0);
    add_ticks(1, 0);
    add_start(16'(WaveTri), 16'd257, 16'd65302, 1'b0);
    add_ticks(137, 0);
    add_start(16'(WaveSaw), 16'd100, 16'd51, 1'b1);
    add_ticks(129, 0);

    queued = 0;
    for (int s = 0; queued < RandomItems; s++) begin
      add_random_run(s % 12 == 0);
    end

    add_start(16'(WaveStep), 16'h0000, 16'h0000, 1'b1);
    add_ticks(55, 0);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || in_valid_i) @(posedge clk_i);
    while (dac_words_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && dac_words_q.size() == 0) begin
      $display("multi_shape_waveform_sequencer_top regression: pass");
    end else begin
      $display("multi_shape_waveform_sequencer_top regression: fail");
    end
    $finish;
  end

endmodule

@@ multi_shape_waveform_sequencer_top.f @@
src/msws_pkg.sv
src/msws_budget.sv
src/msws_core.sv
src/multi_shape_waveform_sequencer_top.sv
tb/sv/tb_multi_shape_waveform_sequencer_top.sv
